>>> rtl/core/memory_image_receiver_defines.svh
// ----------------------------------------------------------------------------
// Memory image receiver assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef MEMORY_IMAGE_RECEIVER_DEFINES_SVH
`define MEMORY_IMAGE_RECEIVER_DEFINES_SVH

// generic check with a fixed message
`define MIR_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("memory_image_receiver assertion failed");

// check with its own message
`define MIR_ASSERT_MSG(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

`endif

>>> rtl/core/mir_pkg.sv
// ----------------------------------------------------------------------------
// Memory image receiver package
// Protocol bytes, event kinds, status and error codes, result record.
// ----------------------------------------------------------------------------
package mir_pkg;

	localparam logic [1:0] KIND_START   = 2'd0;
	localparam logic [1:0] KIND_BYTE    = 2'd1;
	localparam logic [1:0] KIND_TIMEOUT = 2'd2;

	localparam logic [7:0] BYTE_END   = 8'h00;
	localparam logic [7:0] BYTE_BLOCK = 8'h01;
	localparam logic [7:0] BYTE_ACK   = 8'haa;
	localparam logic [7:0] BYTE_SYNC  = 8'h55;
	localparam logic [7:0] BYTE_OVER  = 8'h78;

	localparam logic [1:0] STATUS_IDLE  = 2'd0;
	localparam logic [1:0] STATUS_BUSY  = 2'd1;
	localparam logic [1:0] STATUS_DONE  = 2'd2;
	localparam logic [1:0] STATUS_ERROR = 2'd3;

	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_SYNC    = 3'd1;
	localparam logic [2:0] ERR_CMD     = 3'd2;
	localparam logic [2:0] ERR_ZERO    = 3'd3;
	localparam logic [2:0] ERR_TOP     = 3'd4;
	localparam logic [2:0] ERR_TIMEOUT = 3'd5;
	localparam logic [2:0] ERR_NODATA  = 3'd6;

	localparam int OUT_DATA_BITS = 72;

	typedef struct packed {
		logic [16:0] extent_high;
		logic [15:0] extent_low;
		logic [2:0]  error_code;
		logic [1:0]  status;
		logic [7:0]  wr_data;
		logic [15:0] wr_addr;
		logic        wr_valid;
		logic [7:0]  tx_byte;
		logic        tx_valid;
	} result_t;

endpackage

>>> rtl/core/mir_step.sv
// ----------------------------------------------------------------------------
// Memory image receiver protocol step
// Holds the protocol state and turns one event into one result record.
// ----------------------------------------------------------------------------
module mir_step #(
	parameter int IMAGE_BYTES = 65536
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  logic [1:0]       kind,
	input  logic [7:0]       rx_byte,
	output mir_pkg::result_t res
);
	import mir_pkg::*;

	localparam logic [16:0] IMAGE_TOP = 17'(IMAGE_BYTES);

	typedef enum logic [9:0] {
		PH_IDLE   = 10'b0000000001,
		PH_SYNC   = 10'b0000000010,
		PH_CMD    = 10'b0000000100,
		PH_CNT_HI = 10'b0000001000,
		PH_CNT_LO = 10'b0000010000,
		PH_ADR_HI = 10'b0000100000,
		PH_ADR_LO = 10'b0001000000,
		PH_DATA   = 10'b0010000000,
		PH_DONE   = 10'b0100000000,
		PH_ERR    = 10'b1000000000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [2:0]  err_q, err_d;
	logic [15:0] count_q, count_d;
	logic [15:0] addr_q, addr_d;
	logic [15:0] wptr_q, wptr_d;
	logic [15:0] left_q, left_d;
	logic        noblk_q, noblk_d;
	logic [15:0] low_q, low_d;
	logic [16:0] high_q, high_d;

	logic [15:0] hdr_addr;
	logic [16:0] hdr_end;
	logic [16:0] blk_end;
	logic        busy;

	assign hdr_addr = {addr_q[15:8], rx_byte};
	assign hdr_end  = {1'b0, hdr_addr} + {1'b0, count_q};
	assign blk_end  = {1'b0, addr_q} + {1'b0, count_q};
	assign busy     = (phase_q != PH_IDLE) && (phase_q != PH_DONE) && (phase_q != PH_ERR);

	always_comb begin
		phase_d = phase_q;
		err_d   = err_q;
		count_d = count_q;
		addr_d  = addr_q;
		wptr_d  = wptr_q;
		left_d  = left_q;
		noblk_d = noblk_q;
		low_d   = low_q;
		high_d  = high_q;
		res     = '0;

		unique case (kind)
			KIND_START: begin
				phase_d      = PH_SYNC;
				err_d        = ERR_NONE;
				noblk_d      = 1'b1;
				low_d        = '0;
				high_d       = '0;
				res.tx_valid = 1'b1;
				res.tx_byte  = BYTE_ACK;
			end
			KIND_TIMEOUT: begin
				if (busy) begin
					phase_d = PH_ERR;
					err_d   = ERR_TIMEOUT;
				end
			end
			KIND_BYTE: begin
				unique case (phase_q)
					PH_SYNC: begin
						if (rx_byte == BYTE_SYNC) begin
							phase_d = PH_CMD;
						end else begin
							phase_d = PH_ERR;
							err_d   = ERR_SYNC;
						end
					end
					PH_CMD: begin
						priority if (rx_byte == BYTE_END) begin
							if (noblk_q) begin
								phase_d = PH_ERR;
								err_d   = ERR_NODATA;
							end else begin
								res.tx_valid = 1'b1;
								res.tx_byte  = BYTE_OVER;
								phase_d      = PH_DONE;
							end
						end else if (rx_byte == BYTE_BLOCK) begin
							res.tx_valid = 1'b1;
							res.tx_byte  = rx_byte;
							phase_d      = PH_CNT_HI;
						end else begin
							phase_d = PH_ERR;
							err_d   = ERR_CMD;
						end
					end
					PH_CNT_HI: begin
						count_d      = {rx_byte, 8'h00};
						res.tx_valid = 1'b1;
						res.tx_byte  = rx_byte;
						phase_d      = PH_CNT_LO;
					end
					PH_CNT_LO: begin
						count_d      = {count_q[15:8], rx_byte};
						res.tx_valid = 1'b1;
						res.tx_byte  = rx_byte;
						phase_d      = PH_ADR_HI;
					end
					PH_ADR_HI: begin
						addr_d       = {rx_byte, 8'h00};
						res.tx_valid = 1'b1;
						res.tx_byte  = rx_byte;
						phase_d      = PH_ADR_LO;
					end
					PH_ADR_LO: begin
						addr_d       = hdr_addr;
						res.tx_valid = 1'b1;
						res.tx_byte  = rx_byte;
						priority if (count_q == 16'd0) begin
							phase_d = PH_ERR;
							err_d   = ERR_ZERO;
						end else if (hdr_end > IMAGE_TOP) begin
							phase_d = PH_ERR;
							err_d   = ERR_TOP;
						end else begin
							wptr_d  = hdr_addr;
							left_d  = count_q;
							phase_d = PH_DATA;
						end
					end
					PH_DATA: begin
						res.wr_valid = 1'b1;
						res.wr_addr  = wptr_q;
						res.wr_data  = rx_byte;
						wptr_d       = wptr_q + 16'd1;
						left_d       = left_q - 16'd1;
						if (left_q == 16'd1) begin
							if (noblk_q || (addr_q < low_q)) begin
								low_d = addr_q;
							end
							if (noblk_q || (blk_end > high_q)) begin
								high_d = blk_end;
							end
							noblk_d      = 1'b0;
							res.tx_valid = 1'b1;
							res.tx_byte  = BYTE_ACK;
							phase_d      = PH_CMD;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase

		unique case (phase_d)
			PH_IDLE: res.status = STATUS_IDLE;
			PH_DONE: res.status = STATUS_DONE;
			PH_ERR: begin
				res.status     = STATUS_ERROR;
				res.error_code = err_d;
			end
			default: res.status = STATUS_BUSY;
		endcase
		res.extent_low  = low_d;
		res.extent_high = high_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			err_q   <= ERR_NONE;
			count_q <= '0;
			addr_q  <= '0;
			wptr_q  <= '0;
			left_q  <= '0;
			noblk_q <= 1'b1;
			low_q   <= '0;
			high_q  <= '0;
		end else if (step_en) begin
			phase_q <= phase_d;
			err_q   <= err_d;
			count_q <= count_d;
			addr_q  <= addr_d;
			wptr_q  <= wptr_d;
			left_q  <= left_d;
			noblk_q <= noblk_d;
			low_q   <= low_d;
			high_q  <= high_d;
		end
	end

endmodule

>>> rtl/core/memory_image_receiver.sv
// An accepted input beat passes the input register and then the result register before its result beat shows on m_*.
// Throughput: one beat per cycle while m_tready takes the result beats; the protocol step is one update per beat.
// s_tready drops only while the input register holds a beat blocked by m_tready.
// Reset (arst_n low): idle phase, empty extents, no beats held.
// ----------------------------------------------------------------------------
// Memory image receiver
// Byte-serial image load receiver: input register, protocol step, result register.
// ----------------------------------------------------------------------------
module memory_image_receiver #(
	parameter int IMAGE_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [1:0]  s_tuser,   // [1:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] tx_byte, [23:8] wr_addr, [31:24] wr_data, [33:32] status,
	// [36:34] error_code, [52:37] extent_low, [69:53] extent_high, [71:70] zero
	output logic [mir_pkg::OUT_DATA_BITS-1:0] m_tdata,
	output logic [1:0]  m_tuser    // [0] tx_valid, [1] wr_valid
);
	import mir_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic [1:0] kind_s1;
	logic       advance;
	logic       out_valid_q;
	result_t    res;
	result_t    res_q;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			kind_s1 <= s_tuser;
		end
	end

	mir_step #(
		.IMAGE_BYTES(IMAGE_BYTES)
	) u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.kind    (kind_s1),
		.rx_byte (byte_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = {res_q.wr_valid, res_q.tx_valid};
	assign m_tdata  = {2'b00, res_q.extent_high, res_q.extent_low, res_q.error_code,
		res_q.status, res_q.wr_data, res_q.wr_addr, res_q.tx_byte};

endmodule

>>> rtl/core/mir_checker.sv
// ----------------------------------------------------------------------------
// Memory image receiver port checker
// Watches the result stream of the top level; bound in below.
// ----------------------------------------------------------------------------
`include "memory_image_receiver_defines.svh"

module mir_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [mir_pkg::OUT_DATA_BITS-1:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import mir_pkg::*;

	`MIR_ASSERT_MSG(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")
	`MIR_ASSERT_MSG(a_wr_busy, m_tvalid && m_tuser[1] |-> m_tdata[33:32] == STATUS_BUSY, "memory write outside a busy transfer")
	`MIR_ASSERT_MSG(a_err_code, m_tvalid |-> ((m_tdata[33:32] == STATUS_ERROR) == (m_tdata[36:34] != ERR_NONE)), "error code disagrees with status")
	`MIR_ASSERT(a_tx_quiet, m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'h00)
	`MIR_ASSERT(a_wr_quiet, m_tvalid && !m_tuser[1] |-> m_tdata[31:8] == 24'h000000)

endmodule

bind memory_image_receiver mir_checker u_mir_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// Memory image receiver testbench
// Drives link events into the receiver and predicts every result beat from a
// behavioral model of the load protocol: start, sync, block header echo,
// data writes, block ack, end, and every error path. The directed tests go
// first, then random transfers under four idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_top;

	import mir_pkg::*;

	localparam int IMAGE_BYTES = 65536;
	localparam int IDLE_LIMIT  = 2000;
	localparam logic [1:0] KIND_IGNORED = 2'd3;

	typedef enum logic [3:0] {
		PH_IDLE, PH_SYNC, PH_CMD, PH_CNT_HI, PH_CNT_LO, PH_ADR_HI, PH_ADR_LO,
		PH_DATA, PH_DONE, PH_FAILED
	} link_phase_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_tdata;
	logic [1:0]  m_tuser;

	// load protocol state as the receiver should hold it
	link_phase_t link_phase   = PH_IDLE;
	logic [2:0]  fail_code    = ERR_NONE;
	logic [15:0] hdr_count    = '0;
	logic [15:0] hdr_addr     = '0;
	logic [16:0] write_ptr    = '0;
	logic [15:0] bytes_left   = '0;
	logic        no_block_yet = 1'b1;
	logic [15:0] ext_low      = '0;
	logic [16:0] ext_high     = '0;

	result_t expected_results[$];
	int          mismatches  = 0;
	int          beats_sent  = 0;
	int          idle_cycles = 0;
	int unsigned send_idle_pct = 0;
	int unsigned rx_stall_pct  = 0;

	memory_image_receiver #(
		.IMAGE_BYTES(IMAGE_BYTES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic link_busy();
		return link_phase >= PH_SYNC && link_phase <= PH_DATA;
	endfunction

	function automatic void link_fail(input logic [2:0] code);
		link_phase = PH_FAILED;
		fail_code  = code;
	endfunction

	function automatic result_t link_step(input logic [1:0] kind, input logic [7:0] b);
		result_t r;
		int unsigned blk_end;
		r = '0;
		if (kind == KIND_START) begin
			link_phase   = PH_SYNC;
			no_block_yet = 1'b1;
			ext_low      = '0;
			ext_high     = '0;
			r.tx_valid   = 1'b1;
			r.tx_byte    = BYTE_ACK;
		end else if (kind == KIND_TIMEOUT) begin
			if (link_busy())
				link_fail(ERR_TIMEOUT);
		end else if (kind == KIND_BYTE) begin
			case (link_phase)
				PH_SYNC: begin
					if (b == BYTE_SYNC)
						link_phase = PH_CMD;
					else
						link_fail(ERR_SYNC);
				end
				PH_CMD: begin
					if (b == BYTE_END) begin
						if (no_block_yet) begin
							link_fail(ERR_NODATA);
						end else begin
							r.tx_valid = 1'b1;
							r.tx_byte  = BYTE_OVER;
							link_phase = PH_DONE;
						end
					end else if (b == BYTE_BLOCK) begin
						r.tx_valid = 1'b1;
						r.tx_byte  = b;
						link_phase = PH_CNT_HI;
					end else begin
						link_fail(ERR_CMD);
					end
				end
				PH_CNT_HI: begin
					hdr_count  = {b, 8'h00};
					r.tx_valid = 1'b1;
					r.tx_byte  = b;
					link_phase = PH_CNT_LO;
				end
				PH_CNT_LO: begin
					hdr_count[7:0] = b;
					r.tx_valid = 1'b1;
					r.tx_byte  = b;
					link_phase = PH_ADR_HI;
				end
				PH_ADR_HI: begin
					hdr_addr   = {b, 8'h00};
					r.tx_valid = 1'b1;
					r.tx_byte  = b;
					link_phase = PH_ADR_LO;
				end
				PH_ADR_LO: begin
					hdr_addr[7:0] = b;
					r.tx_valid = 1'b1;
					r.tx_byte  = b;
					blk_end = 32'(hdr_addr) + 32'(hdr_count);
					if (hdr_count == 0) begin
						link_fail(ERR_ZERO);
					end else if (blk_end > IMAGE_BYTES) begin
						link_fail(ERR_TOP);
					end else begin
						write_ptr  = {1'b0, hdr_addr};
						bytes_left = hdr_count;
						link_phase = PH_DATA;
					end
				end
				PH_DATA: begin
					r.wr_valid = 1'b1;
					r.wr_addr  = write_ptr[15:0];
					r.wr_data  = b;
					write_ptr  = write_ptr + 17'd1;
					bytes_left = bytes_left - 16'd1;
					if (bytes_left == 0) begin
						blk_end = 32'(hdr_addr) + 32'(hdr_count);
						if (no_block_yet || hdr_addr < ext_low)
							ext_low = hdr_addr;
						if (no_block_yet || blk_end > ext_high)
							ext_high = blk_end[16:0];
						no_block_yet = 1'b0;
						r.tx_valid   = 1'b1;
						r.tx_byte    = BYTE_ACK;
						link_phase   = PH_CMD;
					end
				end
				default: ;
			endcase
		end
		if (link_phase == PH_IDLE) begin
			r.status = STATUS_IDLE;
		end else if (link_busy()) begin
			r.status = STATUS_BUSY;
		end else if (link_phase == PH_DONE) begin
			r.status = STATUS_DONE;
		end else begin
			r.status     = STATUS_ERROR;
			r.error_code = fail_code;
		end
		r.extent_low  = ext_low;
		r.extent_high = ext_high;
		return r;
	endfunction

	task automatic send_beat(input logic [1:0] kind, input logic [7:0] data);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= data;
		do @(posedge clk); while (!s_tready);
		expected_results.push_back(link_step(kind, data));
		beats_sent++;
	endtask

	task automatic send_header(input int unsigned count, input int unsigned addr);
		send_beat(KIND_BYTE, BYTE_BLOCK);
		send_beat(KIND_BYTE, count[15:8]);
		send_beat(KIND_BYTE, count[7:0]);
		send_beat(KIND_BYTE, addr[15:8]);
		send_beat(KIND_BYTE, addr[7:0]);
	endtask

	task automatic check_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %0h got %0h", field, want, got);
		end
	endtask

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= rx_stall_pct);

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result beat with nothing expected: %h", m_tdata);
			end else begin
				want = expected_results.pop_front();
				check_field("tx_valid", 32'(want.tx_valid), 32'(m_tuser[0]));
				check_field("wr_valid", 32'(want.wr_valid), 32'(m_tuser[1]));
				check_field("tx_byte", 32'(want.tx_byte), 32'(m_tdata[7:0]));
				check_field("wr_addr", 32'(want.wr_addr), 32'(m_tdata[23:8]));
				check_field("wr_data", 32'(want.wr_data), 32'(m_tdata[31:24]));
				check_field("status", 32'(want.status), 32'(m_tdata[33:32]));
				check_field("error_code", 32'(want.error_code), 32'(m_tdata[36:34]));
				check_field("extent_low", 32'(want.extent_low), 32'(m_tdata[52:37]));
				check_field("extent_high", 32'(want.extent_high), 32'(m_tdata[69:53]));
				check_field("pad", 0, 32'(m_tdata[71:70]));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// bytes, timeouts and unused kinds before any start are all ignored
	task automatic test_stray_events();
		send_beat(KIND_BYTE, 8'hff);
		send_beat(KIND_TIMEOUT, 8'h00);
		send_beat(KIND_IGNORED, 8'h00);
	endtask

	task automatic test_sync_error();
		send_beat(KIND_START, 8'h00);
		send_beat(KIND_BYTE, BYTE_ACK);
		send_beat(KIND_BYTE, BYTE_SYNC);
		send_beat(KIND_TIMEOUT, 8'hff);
	endtask

	task automatic test_end_without_block();
		send_beat(KIND_START, 8'hff);
		send_beat(KIND_BYTE, BYTE_SYNC);
		send_beat(KIND_BYTE, BYTE_END);
	endtask

	task automatic test_bad_command();
		send_beat(KIND_START, 8'h00);
		send_beat(KIND_BYTE, BYTE_SYNC);
		send_beat(KIND_BYTE, 8'hfe);
	endtask

	task automatic test_zero_count();
		send_beat(KIND_START, 8'h00);
		send_beat(KIND_BYTE, BYTE_SYNC);
		send_header(0, 32'h0000ffff);
	endtask

	task automatic test_past_top();
		send_beat(KIND_START, 8'h00);
		send_beat(KIND_BYTE, BYTE_SYNC);
		send_header(32'h0000ffff, 2);
	endtask

	// single byte at the top address, clean end, then stray events, a restart and a timeout
	task automatic test_full_transfer();
		send_beat(KIND_START, 8'h00);
		send_beat(KIND_BYTE, BYTE_SYNC);
		send_header(1, 32'h0000ffff);
		send_beat(KIND_BYTE, 8'hff);
		send_beat(KIND_IGNORED, 8'hff);
		send_beat(KIND_BYTE, BYTE_END);
		send_beat(KIND_BYTE, 8'h12);
		send_beat(KIND_TIMEOUT, 8'h00);
		send_beat(KIND_START, 8'h00);
		send_beat(KIND_TIMEOUT, 8'h00);
	endtask

	task automatic run_transfer();
		int unsigned n_blocks, count, addr, pick;
		send_beat(KIND_START, 8'($urandom));
		if ($urandom_range(99) < 5)
			send_beat(KIND_BYTE, 8'($urandom));
		else
			send_beat(KIND_BYTE, BYTE_SYNC);
		n_blocks = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 4);
		for (int i = 0; i < n_blocks && link_phase == PH_CMD; i++) begin
			pick = $urandom_range(99);
			if (pick < 2) begin
				count = 0;
				addr  = $urandom_range(0, 65535);
			end else if (pick < 5) begin
				count = $urandom_range(2, 65535);
				addr  = $urandom_range(IMAGE_BYTES + 1 - count, 65535);
			end else begin
				count = (pick < 9) ? $urandom_range(9, 300) : $urandom_range(1, 8);
				if ($urandom_range(99) < 10)
					addr = IMAGE_BYTES - count;
				else
					addr = $urandom_range(0, IMAGE_BYTES - count);
			end
			if ($urandom_range(99) < 3)
				send_beat(KIND_BYTE, 8'($urandom_range(2, 255)));
			else
				send_header(count, addr);
			for (int j = 0; j < count && link_phase == PH_DATA; j++) begin
				pick = $urandom_range(199);
				if (pick == 0)
					send_beat(KIND_TIMEOUT, 8'($urandom));
				else if (pick == 1)
					send_beat(KIND_START, 8'($urandom));
				else if (pick == 2)
					send_beat(KIND_IGNORED, 8'($urandom));
				send_beat(KIND_BYTE, 8'($urandom));
			end
		end
		if (link_phase == PH_CMD)
			send_beat(KIND_BYTE, BYTE_END);
		if ($urandom_range(99) < 5)
			send_beat(KIND_BYTE, 8'($urandom));
	endtask

	task automatic test_random_traffic(input int unsigned idle_pct,
			input int unsigned stall_pct, input int n_beats);
		int target;
		send_idle_pct = idle_pct;
		rx_stall_pct  = stall_pct;
		target = beats_sent + n_beats;
		while (beats_sent < target)
			run_transfer();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_stray_events();
		test_sync_error();
		test_end_without_block();
		test_bad_command();
		test_zero_count();
		test_past_top();
		test_full_transfer();
		test_random_traffic(0, 0, 200);
		test_random_traffic(68, 0, 200);
		test_random_traffic(0, 68, 200);
		test_random_traffic(35, 35, 200);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
